// File: rtl/core/torus_point_zbuffer_shader_macros.svh
`ifndef TORUS_POINT_ZBUFFER_SHADER_MACROS_SVH
`define TORUS_POINT_ZBUFFER_SHADER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TPZS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TPZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tpzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point shader package
// Field widths, command and status codes, fixed-point constants and the
// sequencer state type shared by the shader files.
// ----------------------------------------------------------------------------
package tpzs_pkg;

  localparam int ANG_W     = 16;
  localparam int ADDR_IN_W = 18;
  localparam int PIX_W     = 20;
  localparam int OUT_PIX_W = 12;
  localparam int DEPTH_W   = 16;
  localparam int SHADE_W   = 4;
  localparam int WORD_W    = DEPTH_W + SHADE_W;
  localparam int REG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int DIV_CNT_W = 4;

  localparam int Q_SH      = 14;
  localparam int XN_SH     = 28;
  localparam int PROJ_SH   = 44;
  localparam int LUM_SH    = 53;

  localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;

  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIDDEN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READ    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SIN_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COS_A = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIN_B = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COS_B = 2'd3;

  localparam logic [SHADE_W-1:0] SHADE_BLANK = 4'd12;
  localparam logic [SHADE_W-1:0] SHADE_MAX   = 4'd11;

  localparam logic signed [ANG_W-1:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [ANG_W-1:0] Q14_ZERO = 16'sd0;
  localparam logic signed [17:0]      Q14_TWO  = 18'sd32768;

  localparam logic signed [48:0] ONE_Q42  = 49'sd1 <<< 42;
  localparam logic signed [48:0] FIVE_Q42 = 49'sd5 <<< 42;
  localparam logic signed [63:0] TRUNC_BIAS = (64'sd1 <<< PROJ_SH) - 64'sd1;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;
  localparam logic [DEPTH_W-1:0]   INV_SAT  = 16'hFFFF;

  localparam logic signed [PIX_W-1:0] PIX_LOW  = -20'sd2048;
  localparam logic signed [PIX_W-1:0] PIX_HIGH = 20'sd2047;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DIV,
    S_PROJ1,
    S_PROJ2,
    S_PROJ3,
    S_ADDR,
    S_LOOK,
    S_CHK,
    S_FIN,
    S_CLR
  } state_t;

  // Clamp a projected coordinate to the 12-bit result field.
  function automatic logic signed [OUT_PIX_W-1:0] sat_pix(
    input logic signed [PIX_W-1:0] v
  );
    logic signed [OUT_PIX_W-1:0] r;
    if (v < PIX_LOW) begin
      r = PIX_LOW[OUT_PIX_W-1:0];
    end else if (v > PIX_HIGH) begin
      r = PIX_HIGH[OUT_PIX_W-1:0];
    end else begin
      r = v[OUT_PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/tpzs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point shader channels
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface tpzs_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [tpzs_pkg::CMD_W-1:0]               cmd;
  logic signed [tpzs_pkg::ANG_W-1:0]        sin_theta;
  logic signed [tpzs_pkg::ANG_W-1:0]        cos_theta;
  logic signed [tpzs_pkg::ANG_W-1:0]        sin_phi;
  logic signed [tpzs_pkg::ANG_W-1:0]        cos_phi;
  logic [tpzs_pkg::ADDR_IN_W-1:0]           cell_address;

  modport source (output valid, cmd, sin_theta, cos_theta, sin_phi, cos_phi,
                  cell_address, input ready);
  modport sink (input valid, cmd, sin_theta, cos_theta, sin_phi, cos_phi,
                cell_address, output ready);
endinterface

interface tpzs_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic [tpzs_pkg::STATUS_W-1:0]            status;
  logic signed [tpzs_pkg::OUT_PIX_W-1:0]    pixel_x;
  logic signed [tpzs_pkg::OUT_PIX_W-1:0]    pixel_y;
  logic [tpzs_pkg::SHADE_W-1:0]             shade;

  modport source (output valid, status, pixel_x, pixel_y, shade, input ready);
  modport sink (input valid, status, pixel_x, pixel_y, shade, output ready);
endinterface

// File: rtl/core/torus_point_zbuffer_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point z-buffer shader
// Rotates and projects one torus surface point per plot command, keeps the
// nearest point per screen cell in a combined depth/shade memory, and serves
// clear and cell read commands.
// ----------------------------------------------------------------------------
//  Channel  Dir   Handshake            Carries
//  req      in    valid/ready          cmd, angle sines/cosines, cell_address
//  rsp      out   valid/ready          status, pixel_x, pixel_y, shade
//  cfg      in    cfg_we (no stall)    cfg_index, cfg_data (rotation sin/cos)
//
// A plot passes three product stages, a 16-step
// restoring divider for the inverse depth, three projection stages and a
// read-modify-write of one memory word.
// A clear sweeps the memory one word per cycle.
// After reset the same sweep runs with req.ready low; configuration writes
// are taken throughout.
// The result sits in an output register, so a stalled rsp only holds the
// block in its final step.
// ----------------------------------------------------------------------------
`include "torus_point_zbuffer_shader_macros.svh"

module torus_point_zbuffer_shader #(
  parameter int WIDTH  = 400,
  parameter int HEIGHT = 400
) (
  input  logic                              clk,
  input  logic                              rst,
  tpzs_req_if.sink                          req,
  tpzs_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [tpzs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [tpzs_pkg::ANG_W-1:0]        cfg_data
);

  localparam int CELLS = WIDTH * HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int KX    = 3 * WIDTH / 8;
  localparam int KY    = 3 * HEIGHT / 4;
  localparam int CX    = WIDTH / 2;
  localparam int CY    = 6 * HEIGHT / 11;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic signed [63:0] OFF_X = 64'(CX) <<< tpzs_pkg::PROJ_SH;
  localparam logic signed [63:0] OFF_Y = 64'(CY) <<< tpzs_pkg::PROJ_SH;

  tpzs_pkg::state_t state, state_next;

  // Configuration registers.
  logic signed [15:0] sin_a, cos_a, sin_b, cos_b;

  // Item registers.
  logic [tpzs_pkg::CMD_W-1:0] op;
  logic signed [15:0] st, ct, sp, cp;
  logic in_range;

  // Product stages.
  logic signed [17:0] h;
  logic signed [33:0] sth, cth;
  logic signed [31:0] stcp, ctcp, spsa, spca;
  logic signed [47:0] m, ccb, csb, u, w, v;
  logic signed [48:0] d;
  logic signed [63:0] xs, ys, lp, rest, lum;
  logic signed [35:0] xn, yn;
  logic near;

  // Divider.
  logic signed [49:0] rem, rem2;
  logic rem_ge;
  logic [tpzs_pkg::DEPTH_W-1:0] q;
  logic [tpzs_pkg::DIV_CNT_W-1:0] div_cnt;

  // Projection.
  logic [tpzs_pkg::DEPTH_W-1:0] inv_c, inv_q;
  logic signed [52:0] px, py;
  logic signed [63:0] tx, ty, tx_t, ty_t;
  logic signed [tpzs_pkg::PIX_W-1:0] xw, yw;
  logic onscreen;
  logic [tpzs_pkg::SHADE_W-1:0] shade_c;

  // Memory.
  logic [tpzs_pkg::WORD_W-1:0] mem [CELLS];
  logic [tpzs_pkg::WORD_W-1:0] mem_q, mem_wd;
  logic [AW-1:0] rd_addr, mem_wa, clr_idx;
  logic mem_we, hit;
  logic clr_report;

  // Pending result and output register.
  logic [tpzs_pkg::STATUS_W-1:0] res_status, out_status;
  logic signed [tpzs_pkg::OUT_PIX_W-1:0] res_x, res_y, out_x, out_y;
  logic [tpzs_pkg::SHADE_W-1:0] res_shade, out_shade;
  logic out_valid, load_out, req_ready;

  assign h    = 18'(cp) + tpzs_pkg::Q14_TWO;
  assign xs   = (64'(ccb) <<< tpzs_pkg::Q_SH) - 64'(m) * 64'(sin_b);
  assign ys   = (64'(csb) <<< tpzs_pkg::Q_SH) + 64'(m) * 64'(cos_b);
  assign lum  = lp - rest;
  assign rem2 = rem <<< 1;
  assign rem_ge = rem2 >= 50'(d);
  assign inv_c = near ? tpzs_pkg::INV_SAT : q;
  assign tx_t = tx[63] ? ((tx + tpzs_pkg::TRUNC_BIAS) >>> tpzs_pkg::PROJ_SH)
                       : (tx >>> tpzs_pkg::PROJ_SH);
  assign ty_t = ty[63] ? ((ty + tpzs_pkg::TRUNC_BIAS) >>> tpzs_pkg::PROJ_SH)
                       : (ty >>> tpzs_pkg::PROJ_SH);
  assign hit  = onscreen && (inv_q > mem_q[tpzs_pkg::WORD_W-1:tpzs_pkg::SHADE_W]);

  // Negative luminance gives shade 0; the integer part saturates at 11.
  always_comb begin
    if (lum[63]) begin
      shade_c = '0;
    end else if (lum[62:tpzs_pkg::LUM_SH] > 10'(tpzs_pkg::SHADE_MAX)) begin
      shade_c = tpzs_pkg::SHADE_MAX;
    end else begin
      shade_c = lum[tpzs_pkg::LUM_SH+tpzs_pkg::SHADE_W-1:tpzs_pkg::LUM_SH];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tpzs_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.cmd == tpzs_pkg::CMD_PLOT) begin
            state_next = tpzs_pkg::S_MUL1;
          end else if (req.cmd == tpzs_pkg::CMD_CLEAR) begin
            state_next = tpzs_pkg::S_CLR;
          end else begin
            state_next = tpzs_pkg::S_LOOK;
          end
        end
      end
      tpzs_pkg::S_MUL1:  state_next = tpzs_pkg::S_MUL2;
      tpzs_pkg::S_MUL2:  state_next = tpzs_pkg::S_MUL3;
      tpzs_pkg::S_MUL3:  state_next = tpzs_pkg::S_DIV;
      tpzs_pkg::S_DIV: begin
        if (div_cnt == tpzs_pkg::DIV_LAST) begin
          state_next = tpzs_pkg::S_PROJ1;
        end
      end
      tpzs_pkg::S_PROJ1: state_next = tpzs_pkg::S_PROJ2;
      tpzs_pkg::S_PROJ2: state_next = tpzs_pkg::S_PROJ3;
      tpzs_pkg::S_PROJ3: state_next = tpzs_pkg::S_ADDR;
      tpzs_pkg::S_ADDR:  state_next = tpzs_pkg::S_LOOK;
      tpzs_pkg::S_LOOK:  state_next = tpzs_pkg::S_CHK;
      tpzs_pkg::S_CHK:   state_next = tpzs_pkg::S_FIN;
      tpzs_pkg::S_FIN: begin
        if (!out_valid || rsp.ready) begin
          state_next = tpzs_pkg::S_IDLE;
        end
      end
      tpzs_pkg::S_CLR: begin
        if (clr_idx == LAST_CELL) begin
          state_next = clr_report ? tpzs_pkg::S_FIN : tpzs_pkg::S_IDLE;
        end
      end
      default: state_next = tpzs_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_ready = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = clr_idx;
    mem_wd    = {{tpzs_pkg::DEPTH_W{1'b0}}, tpzs_pkg::SHADE_BLANK};
    load_out  = 1'b0;
    case (state)
      tpzs_pkg::S_IDLE: req_ready = 1'b1;
      tpzs_pkg::S_CLR:  mem_we = 1'b1;
      tpzs_pkg::S_CHK: begin
        mem_we = (op == tpzs_pkg::CMD_PLOT) && hit;
        mem_wa = rd_addr;
        mem_wd = {inv_q, res_shade};
      end
      tpzs_pkg::S_FIN:  load_out = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign req.ready   = req_ready;
  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.pixel_x = out_x;
  assign rsp.pixel_y = out_y;
  assign rsp.shade   = out_shade;

  // Control registers. Reset starts the memory clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tpzs_pkg::S_CLR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
      sin_a      <= tpzs_pkg::Q14_ZERO;
      cos_a      <= tpzs_pkg::Q14_ONE;
      sin_b      <= tpzs_pkg::Q14_ZERO;
      cos_b      <= tpzs_pkg::Q14_ONE;
    end else begin
      state <= state_next;
      if (state == tpzs_pkg::S_IDLE && req.valid) begin
        clr_idx    <= '0;
        clr_report <= 1'b1;
      end else if (state == tpzs_pkg::S_CLR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          tpzs_pkg::REG_SIN_A: sin_a <= cfg_data;
          tpzs_pkg::REG_COS_A: cos_a <= cfg_data;
          tpzs_pkg::REG_SIN_B: sin_b <= cfg_data;
          tpzs_pkg::REG_COS_B: cos_b <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Depth and shade word per cell: {inverse depth, shade}.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_x      <= res_x;
      out_y      <= res_y;
      out_shade  <= res_shade;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      tpzs_pkg::S_IDLE: begin
        op       <= req.cmd;
        st       <= req.sin_theta;
        ct       <= req.cos_theta;
        sp       <= req.sin_phi;
        cp       <= req.cos_phi;
        in_range <= 32'(req.cell_address) < 32'(CELLS);
        rd_addr  <= AW'(req.cell_address);
      end
      tpzs_pkg::S_MUL1: begin
        sth  <= 34'(st) * 34'(h);
        cth  <= 34'(ct) * 34'(h);
        stcp <= 32'(st) * 32'(cp);
        ctcp <= 32'(ct) * 32'(cp);
        spsa <= 32'(sp) * 32'(sin_a);
        spca <= 32'(sp) * 32'(cos_a);
      end
      tpzs_pkg::S_MUL2: begin
        m   <= 48'(sth) * 48'(cos_a) - (48'(spsa) <<< tpzs_pkg::Q_SH);
        d   <= 49'(sth) * 49'(sin_a) + (49'(spca) <<< tpzs_pkg::Q_SH)
               + tpzs_pkg::FIVE_Q42;
        ccb <= 48'(cth) * 48'(cos_b);
        csb <= 48'(cth) * 48'(sin_b);
        u   <= (48'(spsa) <<< tpzs_pkg::Q_SH) - 48'(stcp) * 48'(cos_a);
        w   <= 48'(stcp) * 48'(sin_a);
        v   <= 48'(ctcp) * 48'(sin_b);
      end
      tpzs_pkg::S_MUL3: begin
        xn      <= 36'(xs >>> tpzs_pkg::XN_SH);
        yn      <= 36'(ys >>> tpzs_pkg::XN_SH);
        lp      <= 64'(u) * 64'(cos_b);
        rest    <= (64'(w) <<< tpzs_pkg::Q_SH) + (64'(spca) <<< tpzs_pkg::XN_SH)
                   + (64'(v) <<< tpzs_pkg::Q_SH);
        // Points at or behind the unit distance saturate the inverse depth.
        near    <= d <= tpzs_pkg::ONE_Q42;
        rem     <= 50'(tpzs_pkg::ONE_Q42);
        q       <= '0;
        div_cnt <= '0;
      end
      tpzs_pkg::S_DIV: begin
        rem     <= rem_ge ? rem2 - 50'(d) : rem2;
        q       <= {q[tpzs_pkg::DEPTH_W-2:0], rem_ge};
        div_cnt <= div_cnt + tpzs_pkg::DIV_CNT_W'(1);
      end
      tpzs_pkg::S_PROJ1: begin
        inv_q     <= inv_c;
        px        <= 53'($signed({1'b0, inv_c})) * 53'(xn);
        py        <= 53'($signed({1'b0, inv_c})) * 53'(yn);
        res_shade <= shade_c;
      end
      tpzs_pkg::S_PROJ2: begin
        tx <= 64'(KX) * 64'(px) + OFF_X;
        ty <= 64'(KY) * 64'(py) + OFF_Y;
      end
      tpzs_pkg::S_PROJ3: begin
        xw <= tpzs_pkg::PIX_W'(tx_t);
        yw <= tpzs_pkg::PIX_W'(ty_t);
      end
      tpzs_pkg::S_ADDR: begin
        onscreen <= (xw > tpzs_pkg::PIX_W'(0)) && (xw < tpzs_pkg::PIX_W'(WIDTH))
                    && (yw > tpzs_pkg::PIX_W'(0)) && (yw < tpzs_pkg::PIX_W'(HEIGHT));
        rd_addr  <= AW'(xw) + AW'(WIDTH) * AW'(yw);
        res_x    <= tpzs_pkg::sat_pix(xw);
        res_y    <= tpzs_pkg::sat_pix(yw);
      end
      tpzs_pkg::S_CHK: begin
        if (op == tpzs_pkg::CMD_PLOT) begin
          res_status <= hit ? tpzs_pkg::ST_STORED : tpzs_pkg::ST_HIDDEN;
        end else begin
          res_status <= tpzs_pkg::ST_READ;
          res_x      <= '0;
          res_y      <= '0;
          res_shade  <= in_range ? mem_q[tpzs_pkg::SHADE_W-1:0]
                                 : tpzs_pkg::SHADE_BLANK;
        end
      end
      tpzs_pkg::S_CLR: begin
        res_status <= tpzs_pkg::ST_CLEARED;
        res_x      <= '0;
        res_y      <= '0;
        res_shade  <= tpzs_pkg::SHADE_BLANK;
      end
      default: ;
    endcase
  end

  `TPZS_ASSERT_NOW(a_div_rem_below_divisor, clk, rst, (state == tpzs_pkg::S_DIV && !near), (rem < 50'(d)), "divider remainder reached the divisor")
  `TPZS_ASSERT_NEXT(a_store_reports_stored, clk, rst, (state == tpzs_pkg::S_CHK && op == tpzs_pkg::CMD_PLOT && hit), (res_status == tpzs_pkg::ST_STORED), "memory write not reported as stored")
  `TPZS_ASSERT_NOW(a_result_from_final_step, clk, rst, $rose(out_valid), ($past(state) == tpzs_pkg::S_FIN), "result presented outside the final step")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point shader testbench
// Drives plot, clear and read transactions through the request channel and
// checks every result against an in-bench model of the rotation, inverse
// depth, projection, shading and depth buffer, under several rotation
// settings and with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import tpzs_pkg::*;

  localparam int WIDTH  = 400;
  localparam int HEIGHT = 400;
  localparam int CELLS  = WIDTH * HEIGHT;
  localparam int WATCHDOG_LIMIT = 1000000;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [ANG_W-1:0] sin_theta;
    logic signed [ANG_W-1:0] cos_theta;
    logic signed [ANG_W-1:0] sin_phi;
    logic signed [ANG_W-1:0] cos_phi;
    logic [ADDR_IN_W-1:0]    cell_address;
  } point_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic signed [OUT_PIX_W-1:0] pixel_x;
    logic signed [OUT_PIX_W-1:0] pixel_y;
    logic [SHADE_W-1:0]          shade;
  } pixel_rsp_t;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ3 = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_SIN_A;
  logic [ANG_W-1:0] cfg_data = '0;

  tpzs_req_if req_ch ();
  tpzs_rsp_if rsp_ch ();

  torus_point_zbuffer_shader #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state.
  longint rot_sin_a = 16384, rot_cos_a = 16384, rot_sin_b = 0, rot_cos_b = 16384;
  logic [DEPTH_W-1:0] depth_mem [0:CELLS-1];
  logic [SHADE_W-1:0] shade_mem [0:CELLS-1];
  int lit_cells[$];

  point_cmd_t pending_cmds[$];
  pixel_rsp_t expected_pixels[$];
  int errors = 0;
  int n_plots = 0, n_stored = 0, n_reads = 0, n_clears = 0;
  bit calm = 0;
  int hold_req = 0, hold_ack = 0, hold_left = 0;
  int quiet_cycles = 0;

  function automatic void wipe_buffers();
    for (int i = 0; i < CELLS; i++) begin
      depth_mem[i] = '0;
      shade_mem[i] = SHADE_BLANK;
    end
  endfunction

  function automatic longint trunc_sh(input longint v, input int n);
    if (v >= 0) return v >>> n;
    return -((-v) >>> n);
  endfunction

  function automatic pixel_rsp_t render_point(input point_cmd_t it);
    longint st, ct, sp, cp, h, sth, m, d, cth, xn, yn, tx, ty, x, y, lum, n;
    longint unsigned inv;
    int o;
    pixel_rsp_t r;
    r = '0;
    if (it.cmd == CMD_CLEAR) begin
      wipe_buffers();
      r.status = ST_CLEARED;
      r.shade = SHADE_BLANK;
      n_clears++;
    end else if (it.cmd != CMD_PLOT) begin
      r.status = ST_READ;
      r.shade = (it.cell_address < CELLS) ? shade_mem[it.cell_address] : SHADE_BLANK;
      n_reads++;
    end else begin
      n_plots++;
      st = it.sin_theta; ct = it.cos_theta; sp = it.sin_phi; cp = it.cos_phi;
      h = cp + 32768;
      sth = st * h;
      m = sth * rot_cos_a - sp * rot_sin_a * 16384;
      d = sth * rot_sin_a + sp * rot_cos_a * 16384 + (longint'(5) <<< 42);
      cth = ct * h;
      if (d <= (longint'(1) <<< 42)) inv = 16'hFFFF;
      else inv = (longint'(1) <<< 58) / longint'(d);
      xn = (cth * rot_cos_b * 16384 - m * rot_sin_b) >>> 28;
      yn = (cth * rot_sin_b * 16384 + m * rot_cos_b) >>> 28;
      tx = longint'(WIDTH / 2) * (longint'(1) <<< 44)
           + longint'(3 * WIDTH / 8) * (longint'(inv) * xn);
      ty = longint'(6 * HEIGHT / 11) * (longint'(1) <<< 44)
           + longint'(3 * HEIGHT / 4) * (longint'(inv) * yn);
      x = trunc_sh(tx, 44);
      y = trunc_sh(ty, 44);
      lum = (sp * rot_sin_a * 16384 - st * cp * rot_cos_a) * rot_cos_b
            - st * cp * rot_sin_a * 16384
            - sp * rot_cos_a * 16384 * 16384
            - ct * cp * rot_sin_b * 16384;
      n = trunc_sh(lum, 53);
      if (n < 0) n = 0;
      if (n > 11) n = 11;
      r.status = ST_HIDDEN;
      if (x > 0 && x < WIDTH && y > 0 && y < HEIGHT) begin
        o = int'(x) + WIDTH * int'(y);
        if (inv > depth_mem[o]) begin
          depth_mem[o] = inv[15:0];
          shade_mem[o] = n[3:0];
          r.status = ST_STORED;
          n_stored++;
          lit_cells.push_back(o);
          if (lit_cells.size() > 64) void'(lit_cells.pop_front());
        end
      end
      r.pixel_x = (x < -2048) ? -12'sd2048 : (x > 2047) ? 12'sd2047 : x[11:0];
      r.pixel_y = (y < -2048) ? -12'sd2048 : (y > 2047) ? 12'sd2047 : y[11:0];
      r.shade = n[3:0];
    end
    return r;
  endfunction

  // Sender.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        point_cmd_t c;
        c = pending_cmds.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= c.cmd;
        req_ch.sin_theta <= c.sin_theta;
        req_ch.cos_theta <= c.cos_theta;
        req_ch.sin_phi <= c.sin_phi;
        req_ch.cos_phi <= c.cos_phi;
        req_ch.cell_address <= c.cell_address;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Prediction at each accepted request transaction.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      point_cmd_t c;
      c.cmd = req_ch.cmd;
      c.sin_theta = req_ch.sin_theta;
      c.cos_theta = req_ch.cos_theta;
      c.sin_phi = req_ch.sin_phi;
      c.cos_phi = req_ch.cos_phi;
      c.cell_address = req_ch.cell_address;
      expected_pixels.push_back(render_point(c));
    end
  end

  // Receiver, with an occasional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 400;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result status=%0d x=%0d y=%0d shade=%0d", $time,
                 rsp_ch.status, rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.shade);
        errors++;
      end else begin
        pixel_rsp_t e;
        e = expected_pixels.pop_front();
        if (rsp_ch.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.pixel_x !== e.pixel_x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, e.pixel_x, rsp_ch.pixel_x);
          errors++;
        end
        if (rsp_ch.pixel_y !== e.pixel_y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, e.pixel_y, rsp_ch.pixel_y);
          errors++;
        end
        if (rsp_ch.shade !== e.shade) begin
          $display("%0t: shade expected %0d actual %0d", $time, e.shade, rsp_ch.shade);
          errors++;
        end
      end
    end
  end

  // Watchdog: a clear sweep is the longest stretch with no transaction.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic point_cmd_t mk_plot(input int st, input int ct, input int sp,
                                         input int cp);
    point_cmd_t c;
    c.cmd = CMD_PLOT;
    c.sin_theta = st[15:0];
    c.cos_theta = ct[15:0];
    c.sin_phi = sp[15:0];
    c.cos_phi = cp[15:0];
    c.cell_address = $urandom_range(0, 262143);
    return c;
  endfunction

  function automatic point_cmd_t mk_read(input int addr);
    point_cmd_t c;
    c = mk_plot($urandom, $urandom, $urandom, $urandom);
    c.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_READ3;
    c.cell_address = addr[17:0];
    return c;
  endfunction

  function automatic int q14(input real v);
    return int'(16384.0 * v);
  endfunction

  function automatic int rand_q14();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic point_cmd_t random_cmd();
    int k;
    real th, ph;
    k = $urandom_range(0, 99);
    if (k < 70) begin
      th = $urandom_range(0, 62831) / 10000.0;
      ph = $urandom_range(0, 62831) / 10000.0;
      return mk_plot(q14($sin(th)), q14($cos(th)), q14($sin(ph)), q14($cos(ph)));
    end else if (k < 78) begin
      return mk_plot(rand_q14(), rand_q14(), rand_q14(), rand_q14());
    end else if (k < 82) begin
      return mk_plot($urandom, $urandom, $urandom, $urandom);
    end else if (k < 93 && lit_cells.size() > 0) begin
      return mk_read(lit_cells[$urandom_range(0, lit_cells.size() - 1)]);
    end else if (k < 97) begin
      return mk_read($urandom_range(0, CELLS - 1));
    end
    return mk_read($urandom_range(CELLS, 262143));
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_pixels.size() > 0 || req_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rotation(input int sa, input int ca, input int sb, input int cb);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_SIN_A; cfg_data <= sa[15:0];
    @(posedge clk);
    cfg_index <= REG_COS_A; cfg_data <= ca[15:0];
    @(posedge clk);
    cfg_index <= REG_SIN_B; cfg_data <= sb[15:0];
    @(posedge clk);
    cfg_index <= REG_COS_B; cfg_data <= cb[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    rot_sin_a = longint'(signed'(sa[15:0])); rot_cos_a = longint'(signed'(ca[15:0]));
    rot_sin_b = longint'(signed'(sb[15:0])); rot_cos_b = longint'(signed'(cb[15:0]));
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_cmds.push_back(random_cmd());
  endtask

  initial begin
    point_cmd_t clr;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_PLOT;
    req_ch.sin_theta = '0; req_ch.cos_theta = '0;
    req_ch.sin_phi = '0; req_ch.cos_phi = '0;
    req_ch.cell_address = '0;
    rsp_ch.ready = 1'b0;
    rot_sin_a = 0;
    wipe_buffers();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: angle extremes, a repeated point (hidden), off screen,
    // negative and saturated luminance, reads in and out of range, clear.
    pending_cmds.push_back(mk_plot(0, 16384, 0, 16384));
    pending_cmds.push_back(mk_plot(0, 16384, 0, 16384));
    pending_cmds.push_back(mk_plot(16384, 0, 0, 16384));
    pending_cmds.push_back(mk_plot(-16384, 0, 0, -16384));
    pending_cmds.push_back(mk_plot(0, -16384, 16384, 0));
    pending_cmds.push_back(mk_plot(0, 16384, -16384, 0));
    pending_cmds.push_back(mk_plot(16384, 16384, 16384, 16384));
    pending_cmds.push_back(mk_plot(-16384, -16384, -16384, -16384));
    pending_cmds.push_back(mk_plot(-32768, 32767, -32768, 32767));
    pending_cmds.push_back(mk_plot(32767, -32768, 32767, -32768));
    pending_cmds.push_back(mk_plot(-32768, -32768, -32768, -32768));
    pending_cmds.push_back(mk_read(0));
    pending_cmds.push_back(mk_read(CELLS - 1));
    pending_cmds.push_back(mk_read(CELLS));
    pending_cmds.push_back(mk_read(262143));
    drain();
    for (int i = 0; i < lit_cells.size() && i < 4; i++)
      pending_cmds.push_back(mk_read(lit_cells[i]));
    clr = mk_read(0);
    clr.cmd = CMD_CLEAR;
    pending_cmds.push_back(clr);
    pending_cmds.push_back(mk_read(200 + WIDTH * 218));
    drain();

    // Set rotation with random commands, with the receiver held off while the sender keeps going.
    set_rotation(q14(0.6), q14(0.8), q14(-0.28), q14(0.96));
    hold_req = hold_req + 1;
    queue_random(140);
    drain();

    // Extreme rotation; one directed point sits at the nearest depth the torus reaches.
    set_rotation(16384, 0, -16384, 0);
    calm = 1;
    pending_cmds.push_back(mk_plot(-16384, 0, 0, 16384));
    queue_random(100);
    drain();
    calm = 0;

    set_rotation(-16384, -16384, 16384, -16384);
    pending_cmds.push_back(clr);
    queue_random(100);
    drain();

    set_rotation(rand_q14(), rand_q14(), rand_q14(), rand_q14());
    queue_random(150);
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d plots (%0d stored), %0d reads, %0d clears over five rotations.",
             n_plots, n_stored, n_reads, n_clears);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_pixels.size());
      $display("tb failed");
    end
    $finish;
  end
endmodule
